// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file dhcptlv_checker.sv
// no dependencies; expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, masked during reset
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication into the next cycle, masked during reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// implication into the next cycle, active during reset too
`define ASSERT_NEXT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/dhcptlv_pkg.sv =====
// shared types and constants of the dhcp option parser
// no dependencies
package dhcptlv_pkg;

  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 32;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_AW     = 3;

  localparam logic [BYTE_W-1:0] TAG_PAD      = 8'd0;
  localparam logic [BYTE_W-1:0] TAG_MASK     = 8'd1;
  localparam logic [BYTE_W-1:0] TAG_ROUTER   = 8'd3;
  localparam logic [BYTE_W-1:0] TAG_DNS      = 8'd6;
  localparam logic [BYTE_W-1:0] TAG_LEASE    = 8'd51;
  localparam logic [BYTE_W-1:0] TAG_MSG_TYPE = 8'd53;
  localparam logic [BYTE_W-1:0] TAG_SERVER   = 8'd54;
  localparam logic [BYTE_W-1:0] TAG_END      = 8'd255;

  localparam logic [WORD_W-1:0] RST_LEASE = 32'd3600;
  localparam logic [WORD_W-1:0] RST_MASK  = 32'hffff_ff00;

  localparam logic REG_LEASE = 1'b0;
  localparam logic REG_MASK  = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              tag_ld;
    logic              len_ld;
    logic              val_ld;
    logic              val_keep;
    logic              commit;
  } token_t;

  typedef struct packed {
    logic              lease_we;
    logic              mask_we;
    logic [WORD_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [BYTE_W-1:0] message_type;
    logic [WORD_W-1:0] subnet_mask;
    logic [WORD_W-1:0] router_address;
    logic [WORD_W-1:0] name_server;
    logic              name_server_valid;
    logic [WORD_W-1:0] lease_seconds;
    logic [WORD_W-1:0] server_identifier;
  } result_t;

endpackage

// ===== rtl/dhcp_option_tlv_parser.sv =====
// top level of the dhcp option parser: config registers, front, queue, back
// depends on dhcptlv_pkg, dhcptlv_front, dhcptlv_fifo, dhcptlv_back
//
// usage
//   input channel: one byte of the options region per item, last_byte set on
//   the final byte; an item is taken when push is high and full is low.
//   result channel: one result per region, on the item marked last; it shows
//   while empty is low and is taken when pop is high.
//   config port: apb style, always ready; 0x0 default lease, 0x4 default
//   mask. a write also reloads the matching held value.
// timing
//   one item per cycle while full is low. the front updates its phase state
//   in the cycle it takes a byte; the back consumes one queued token per cycle
//   unless a last token meets a waiting result; the result is registered.
// reset and stall
//   synchronous reset clears the queue, the parse state and the result
//   valid flag and loads the reset defaults. while the result waits, the back
//   keeps taking non-final tokens; a second last token waits in the two-entry
//   queue and full rises once the queue fills.
module dhcp_option_tlv_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_option_byte,
  input  logic        in_last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_message_type,
  output logic [31:0] out_subnet_mask,
  output logic [31:0] out_router_address,
  output logic [31:0] out_name_server,
  output logic        out_name_server_valid,
  output logic [31:0] out_lease_seconds,
  output logic [31:0] out_server_identifier,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dhcptlv_pkg::*;

  logic [WORD_W-1:0] dflt_lease_r, dflt_mask_r;
  logic              wr_en, accept;
  cfg_wr_t           cfg_wr;
  token_t            front_tok, q_tok;
  logic              q_full, q_valid, q_pop;
  result_t           res;
  logic              res_valid;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_MASK) ? dflt_mask_r : dflt_lease_r;

  assign cfg_wr.lease_we = wr_en && (paddr[2] == REG_LEASE);
  assign cfg_wr.mask_we  = wr_en && (paddr[2] == REG_MASK);
  assign cfg_wr.data     = pwdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_lease_r <= RST_LEASE;
      dflt_mask_r  <= RST_MASK;
    end else begin
      if (cfg_wr.lease_we) dflt_lease_r <= pwdata;
      if (cfg_wr.mask_we)  dflt_mask_r  <= pwdata;
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  dhcptlv_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .option_byte (in_option_byte),
    .last_byte   (in_last_byte),
    .tok         (front_tok)
  );

  dhcptlv_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (accept),
    .wr_tok   (front_tok),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_tok   (q_tok),
    .rd_en    (q_pop)
  );

  dhcptlv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok_valid  (q_valid),
    .tok        (q_tok),
    .tok_pop    (q_pop),
    .cfg_wr     (cfg_wr),
    .dflt_lease (dflt_lease_r),
    .dflt_mask  (dflt_mask_r),
    .res        (res),
    .res_valid  (res_valid),
    .res_pop    (pop)
  );

  assign empty                 = !res_valid;
  assign out_message_type      = res.message_type;
  assign out_subnet_mask       = res.subnet_mask;
  assign out_router_address    = res.router_address;
  assign out_name_server       = res.name_server;
  assign out_name_server_valid = res.name_server_valid;
  assign out_lease_seconds     = res.lease_seconds;
  assign out_server_identifier = res.server_identifier;

endmodule

// ===== rtl/dhcptlv_fifo.sv =====
// short token queue between the parser front and back
// depends on dhcptlv_pkg
module dhcptlv_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  dhcptlv_pkg::token_t wr_tok,
  output logic                full,
  output logic                rd_valid,
  output dhcptlv_pkg::token_t rd_tok,
  input  logic                rd_en
);
  import dhcptlv_pkg::*;

  token_t             mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic               do_wr, do_rd;

  assign full     = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_tok   = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_tok;
    end
  end

endmodule

// ===== rtl/dhcptlv_front.sv =====
// parser front: tracks tag, length, value and stop phases and classifies each item
// depends on dhcptlv_pkg
module dhcptlv_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          option_byte,
  input  logic                last_byte,
  output dhcptlv_pkg::token_t tok
);
  import dhcptlv_pkg::*;

  localparam logic [1:0] PH_TAG  = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_VAL  = 2'd2;
  localparam logic [1:0] PH_STOP = 2'd3;

  logic [1:0]        phase_r, phase_nxt;
  logic [BYTE_W-1:0] remain_r, remain_nxt;
  logic [2:0]        vcnt_r, vcnt_nxt;

  always_comb begin
    phase_nxt    = phase_r;
    remain_nxt   = remain_r;
    vcnt_nxt     = vcnt_r;
    tok          = '0;
    tok.data     = option_byte;
    tok.last     = last_byte;
    case (phase_r)
      PH_TAG: begin
        if (option_byte == TAG_END) begin
          phase_nxt = PH_STOP;
        end else if (option_byte != TAG_PAD) begin
          tok.tag_ld = 1'b1;
          phase_nxt  = PH_LEN;
        end
      end
      PH_LEN: begin
        tok.len_ld = 1'b1;
        remain_nxt = option_byte;
        vcnt_nxt   = '0;
        if (option_byte == '0) begin
          tok.commit = 1'b1;
          phase_nxt  = PH_TAG;
        end else begin
          phase_nxt = PH_VAL;
        end
      end
      PH_VAL: begin
        tok.val_ld   = 1'b1;
        tok.val_keep = (vcnt_r < 3'd4);
        if (vcnt_r < 3'd4) begin
          vcnt_nxt = vcnt_r + 1'b1;
        end
        remain_nxt = remain_r - 1'b1;
        if (remain_r == 8'd1) begin
          tok.commit = 1'b1;
          phase_nxt  = PH_TAG;
        end
      end
      default: begin
      end
    endcase
    if (last_byte) begin
      phase_nxt  = PH_TAG;
      remain_nxt = '0;
      vcnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TAG;
      remain_r <= '0;
      vcnt_r   <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      remain_r <= remain_nxt;
      vcnt_r   <= vcnt_nxt;
    end
  end

endmodule

// ===== rtl/dhcptlv_back.sv =====
// parser back: assembles option values, keeps the held fields, emits results
// depends on dhcptlv_pkg
module dhcptlv_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 tok_valid,
  input  dhcptlv_pkg::token_t  tok,
  output logic                 tok_pop,
  input  dhcptlv_pkg::cfg_wr_t cfg_wr,
  input  logic [31:0]          dflt_lease,
  input  logic [31:0]          dflt_mask,
  output dhcptlv_pkg::result_t res,
  output logic                 res_valid,
  input  logic                 res_pop
);
  import dhcptlv_pkg::*;

  logic [BYTE_W-1:0] tag_r, tag_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;
  logic [WORD_W-1:0] vs_r, vs_nxt;
  result_t           held_r, held_nxt, held_cur;
  result_t           res_r;
  logic              res_valid_r, res_valid_nxt;
  logic [BYTE_W-1:0] len_eff;
  logic              n_is4, n_ge4, n_is1;

  assign tok_pop   = tok_valid && (!tok.last || !res_valid_r || res_pop);
  assign res       = res_r;
  assign res_valid = res_valid_r;
  assign len_eff   = tok.len_ld ? tok.data : len_r;
  assign n_is4     = (len_eff == 8'd4);
  assign n_ge4     = (len_eff >= 8'd4);
  assign n_is1     = (len_eff == 8'd1);

  always_comb begin
    tag_nxt       = tag_r;
    len_nxt       = len_r;
    vs_nxt        = vs_r;
    held_cur      = held_r;
    held_nxt      = held_r;
    res_valid_nxt = res_valid_r && !res_pop;
    if (tok_pop) begin
      if (tok.tag_ld) begin
        tag_nxt = tok.data;
      end
      if (tok.len_ld) begin
        len_nxt = tok.data;
        vs_nxt  = '0;
      end
      if (tok.val_ld && tok.val_keep) begin
        vs_nxt = {vs_r[WORD_W-BYTE_W-1:0], tok.data};
      end
      if (tok.commit) begin
        case (tag_r)
          TAG_MASK: begin
            if (n_is4) held_cur.subnet_mask = vs_nxt;
          end
          TAG_ROUTER: begin
            if (n_ge4) held_cur.router_address = vs_nxt;
          end
          TAG_DNS: begin
            if (n_ge4) begin
              held_cur.name_server       = vs_nxt;
              held_cur.name_server_valid = 1'b1;
            end
          end
          TAG_LEASE: begin
            if (n_is4) held_cur.lease_seconds = vs_nxt;
          end
          TAG_MSG_TYPE: begin
            if (n_is1) held_cur.message_type = vs_nxt[BYTE_W-1:0];
          end
          TAG_SERVER: begin
            if (n_is4) held_cur.server_identifier = vs_nxt;
          end
          default: begin
          end
        endcase
      end
      held_nxt = held_cur;
      if (tok.last) begin
        res_valid_nxt = 1'b1;
        tag_nxt       = '0;
        len_nxt       = '0;
        vs_nxt        = '0;
        held_nxt      = '0;
        held_nxt.subnet_mask   = dflt_mask;
        held_nxt.lease_seconds = dflt_lease;
      end
    end
    if (cfg_wr.lease_we) begin
      held_nxt.lease_seconds = cfg_wr.data;
    end
    if (cfg_wr.mask_we) begin
      held_nxt.subnet_mask = cfg_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r       <= '0;
      len_r       <= '0;
      vs_r        <= '0;
      held_r      <= '{message_type: '0, subnet_mask: RST_MASK, router_address: '0,
                       name_server: '0, name_server_valid: 1'b0,
                       lease_seconds: RST_LEASE, server_identifier: '0};
      res_valid_r <= 1'b0;
    end else begin
      tag_r       <= tag_nxt;
      len_r       <= len_nxt;
      vs_r        <= vs_nxt;
      held_r      <= held_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop && tok.last) begin
      res_r <= held_cur;
    end
  end

endmodule

// ===== rtl/dhcptlv_checker.sv =====
// port level checks of the dhcp option parser, bound to the top level
// depends on assert_macros.svh and dhcp_option_tlv_parser
`include "assert_macros.svh"

module dhcptlv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] out_subnet_mask,
  input logic [31:0] out_name_server,
  input logic        out_name_server_valid,
  input logic        psel,
  input logic        pready
);

  // reset leaves no result waiting and the queue open
  `ASSERT_NEXT_RST(a_reset_clears, !rst_n, empty && !full)

  // a stalled result stays valid and keeps its subnet mask
  `ASSERT_NEXT(a_stall_holds, !empty && !pop, !empty && $stable(out_subnet_mask))

  // a name server address only comes with its valid flag
  `ASSERT_IMP(a_dns_flag, !empty && !out_name_server_valid, out_name_server == 32'd0)

  // the config port never waits
  `ASSERT_IMP(a_cfg_ready, psel, pready)

endmodule

bind dhcp_option_tlv_parser dhcptlv_checker u_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .push                  (push),
  .full                  (full),
  .empty                 (empty),
  .pop                   (pop),
  .out_subnet_mask       (out_subnet_mask),
  .out_name_server       (out_name_server),
  .out_name_server_valid (out_name_server_valid),
  .psel                  (psel),
  .pready                (pready)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for dhcp_option_tlv_parser: option bytes go in, parsed lease
// parameters are predicted per region and checked field by field as they come out
// depends on dhcptlv_pkg and the dhcp_option_tlv_parser rtl
module tb;
  import dhcptlv_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;

  typedef enum logic [1:0] {AWAIT_TAG, AWAIT_LEN, IN_VALUE, STOPPED} parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } region_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_option_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_message_type;
  logic [31:0] out_subnet_mask;
  logic [31:0] out_router_address;
  logic [31:0] out_name_server;
  logic        out_name_server_valid;
  logic [31:0] out_lease_seconds;
  logic [31:0] out_server_identifier;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  region_byte_t region_bytes[$];
  result_t      expected_params[$];

  // parser state mirrored by the prediction
  parse_phase_t phase = AWAIT_TAG;
  logic [7:0]   opt_tag = '0;
  logic [7:0]   opt_len = '0;
  logic [7:0]   val_left = '0;
  logic [31:0]  val_acc = '0;
  logic [31:0]  dflt_lease = RST_LEASE;
  logic [31:0]  dflt_mask = RST_MASK;
  result_t      held;

  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  logic rx_hold = 1'b0;
  logic hold_go = 1'b0;
  int   fail_count = 0;

  dhcp_option_tlv_parser dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .push                 (push),
    .full                 (full),
    .in_option_byte       (in_option_byte),
    .in_last_byte         (in_last_byte),
    .empty                (empty),
    .pop                  (pop),
    .out_message_type     (out_message_type),
    .out_subnet_mask      (out_subnet_mask),
    .out_router_address   (out_router_address),
    .out_name_server      (out_name_server),
    .out_name_server_valid(out_name_server_valid),
    .out_lease_seconds    (out_lease_seconds),
    .out_server_identifier(out_server_identifier),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void restore_defaults();
    phase = AWAIT_TAG;
    opt_tag = '0;
    opt_len = '0;
    val_left = '0;
    val_acc = '0;
    held.message_type = '0;
    held.subnet_mask = dflt_mask;
    held.router_address = '0;
    held.name_server = '0;
    held.name_server_valid = 1'b0;
    held.lease_seconds = dflt_lease;
    held.server_identifier = '0;
  endfunction

  function automatic void apply_option();
    case (opt_tag)
      TAG_MASK:     if (opt_len == 8'd4) held.subnet_mask = val_acc;
      TAG_ROUTER:   if (opt_len >= 8'd4) held.router_address = val_acc;
      TAG_DNS: begin
        if (opt_len >= 8'd4) begin
          held.name_server = val_acc;
          held.name_server_valid = 1'b1;
        end
      end
      TAG_LEASE:    if (opt_len == 8'd4) held.lease_seconds = val_acc;
      TAG_MSG_TYPE: if (opt_len == 8'd1) held.message_type = val_acc[7:0];
      TAG_SERVER:   if (opt_len == 8'd4) held.server_identifier = val_acc;
      default: ;
    endcase
  endfunction

  function automatic void parse_option_byte(input logic [7:0] b, input logic last);
    logic [7:0] pos;
    case (phase)
      AWAIT_TAG: begin
        if (b == TAG_END) begin
          phase = STOPPED;
        end else if (b != TAG_PAD) begin
          opt_tag = b;
          phase = AWAIT_LEN;
        end
      end
      AWAIT_LEN: begin
        opt_len = b;
        val_left = b;
        val_acc = '0;
        if (b == 8'd0) begin
          apply_option();
          phase = AWAIT_TAG;
        end else begin
          phase = IN_VALUE;
        end
      end
      IN_VALUE: begin
        pos = opt_len - val_left;
        if (pos < 8'd4) val_acc = {val_acc[23:0], b};
        val_left = val_left - 8'd1;
        if (val_left == 8'd0) begin
          apply_option();
          phase = AWAIT_TAG;
        end
      end
      default: ;
    endcase
    if (last) begin
      expected_params.push_back(held);
      restore_defaults();
    end
  endfunction

  function automatic void check_params();
    result_t want;
    if (expected_params.size() == 0) begin
      $error("result with no region pending");
      fail_count++;
      return;
    end
    want = expected_params.pop_front();
    if (out_message_type !== want.message_type) begin
      $error("message_type expected %0h got %0h", want.message_type, out_message_type);
      fail_count++;
    end
    if (out_subnet_mask !== want.subnet_mask) begin
      $error("subnet_mask expected %0h got %0h", want.subnet_mask, out_subnet_mask);
      fail_count++;
    end
    if (out_router_address !== want.router_address) begin
      $error("router_address expected %0h got %0h", want.router_address, out_router_address);
      fail_count++;
    end
    if (out_name_server !== want.name_server) begin
      $error("name_server expected %0h got %0h", want.name_server, out_name_server);
      fail_count++;
    end
    if (out_name_server_valid !== want.name_server_valid) begin
      $error("name_server_valid expected %0h got %0h", want.name_server_valid,
             out_name_server_valid);
      fail_count++;
    end
    if (out_lease_seconds !== want.lease_seconds) begin
      $error("lease_seconds expected %0h got %0h", want.lease_seconds, out_lease_seconds);
      fail_count++;
    end
    if (out_server_identifier !== want.server_identifier) begin
      $error("server_identifier expected %0h got %0h", want.server_identifier,
             out_server_identifier);
      fail_count++;
    end
  endfunction

  function automatic int queue_region(input logic [7:0] pkt[$]);
    region_byte_t item;
    for (int i = 0; i < pkt.size(); i++) begin
      item.data = pkt[i];
      item.last = (i == pkt.size() - 1);
      region_bytes.push_back(item);
    end
    return pkt.size();
  endfunction

  function automatic void push_tlv(ref logic [7:0] pkt[$], input logic [7:0] tag,
                                   input int len);
    int n;
    n = len;
    if ($urandom_range(7) == 0) n = $urandom_range(8);
    else if ($urandom_range(49) == 0) n = $urandom_range(255, 200);
    pkt.push_back(tag);
    pkt.push_back(8'(n));
    for (int i = 0; i < n; i++) pkt.push_back(8'($urandom_range(255)));
  endfunction

  function automatic int add_region(input int max_opts);
    logic [7:0] pkt[$];
    int n_opts;
    int cut;
    n_opts = $urandom_range(max_opts, 1);
    for (int k = 0; k < n_opts; k++) begin
      case ($urandom_range(9))
        0: pkt.push_back(TAG_PAD);
        1: push_tlv(pkt, TAG_MASK, 4);
        2: push_tlv(pkt, TAG_ROUTER, $urandom_range(8, 4));
        3: push_tlv(pkt, TAG_DNS, $urandom_range(8, 4));
        4: push_tlv(pkt, TAG_LEASE, 4);
        5: push_tlv(pkt, TAG_MSG_TYPE, 1);
        6: push_tlv(pkt, TAG_SERVER, 4);
        7: push_tlv(pkt, 8'($urandom_range(254, 1)), $urandom_range(6));
        8: begin
          pkt.push_back(TAG_END);
          repeat ($urandom_range(3)) pkt.push_back(8'($urandom_range(255)));
          k = n_opts;
        end
        default: repeat ($urandom_range(2, 1)) pkt.push_back(8'($urandom_range(255)));
      endcase
    end
    // cut the region short now and then so the last option may be truncated
    if (pkt.size() > 1 && $urandom_range(4) == 0) begin
      cut = $urandom_range(pkt.size() > 3 ? 3 : pkt.size() - 1, 1);
      repeat (cut) void'(pkt.pop_back());
    end
    if (pkt.size() == 0) pkt.push_back(8'($urandom_range(255)));
    return queue_region(pkt);
  endfunction

  // sender: offer the oldest pending byte at the falling edge
  always @(negedge clk) begin
    if (region_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
      push <= 1'b1;
      in_option_byte <= region_bytes[0].data;
      in_last_byte <= region_bytes[0].last;
    end else begin
      push <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      parse_option_byte(in_option_byte, in_last_byte);
      void'(region_bytes.pop_front());
    end
  end

  // receiver
  always @(negedge clk) begin
    pop <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) check_params();
  end

  // long receiver hold-off so the queue fills and full rises
  initial begin
    wait (hold_go);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold <= 1'b0;
  end

  task automatic settle();
    while (region_bytes.size() != 0 || expected_params.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== value) begin
      $error("prdata expected %0h got %0h", value, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_LEASE) begin
      dflt_lease = value;
      held.lease_seconds = value;
    end else begin
      dflt_mask = value;
      held.subnet_mask = value;
    end
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int n_items,
                           input int max_opts);
    int added;
    added = 0;
    @(posedge clk);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    while (added < n_items) added += add_region(max_opts);
    settle();
  endtask

  initial begin
    logic [7:0] pkt[$];
    restore_defaults();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // message type, router longer than four bytes, end tag as last byte
    pkt = '{TAG_MSG_TYPE, 8'd1, 8'd5, TAG_ROUTER, 8'd6, 8'd10, 8'd0, 8'd0, 8'd1,
            8'd7, 8'd7, TAG_END};
    void'(queue_region(pkt));
    // all-ones mask, pad as last byte
    pkt = '{TAG_MASK, 8'd4, 8'hff, 8'hff, 8'hff, 8'hff, TAG_PAD};
    void'(queue_region(pkt));
    // wrong length, zero length, unknown tag, truncated value
    pkt = '{TAG_MSG_TYPE, 8'd2, 8'd1, 8'd1, TAG_SERVER, 8'd0, 8'd200, 8'd1, 8'd9,
            TAG_DNS, 8'd4, 8'd1};
    void'(queue_region(pkt));
    // truncated after the tag
    pkt = '{TAG_LEASE};
    void'(queue_region(pkt));
    settle();

    write_reg(REG_LEASE, 32'h0000_0000);
    write_reg(REG_MASK, 32'h0000_0000);
    run_phase(0, 0, 400, 6);

    write_reg(REG_LEASE, 32'hffff_ffff);
    write_reg(REG_MASK, 32'hffff_ffff);
    run_phase(62, 0, 400, 6);

    write_reg(REG_LEASE, $urandom());
    write_reg(REG_MASK, $urandom());
    run_phase(0, 62, 400, 6);

    write_reg(REG_LEASE, $urandom());
    write_reg(REG_MASK, $urandom());
    run_phase(34, 34, 400, 6);

    write_reg(REG_LEASE, RST_LEASE);
    write_reg(REG_MASK, RST_MASK);
    hold_go = 1'b1;
    run_phase(0, 0, 300, 1);

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== dhcp_option_tlv_parser.f =====
+incdir+rtl
rtl/dhcptlv_pkg.sv
rtl/dhcptlv_fifo.sv
rtl/dhcptlv_front.sv
rtl/dhcptlv_back.sv
rtl/dhcp_option_tlv_parser.sv
rtl/dhcptlv_checker.sv
verif/tb.sv
